// ----- rtl/tspan_pkg.sv -----
// Shared types and constants of the planar texture span drawer.
package tspan_pkg;

   localparam int SCREEN_WIDTH = 320;

   localparam int X_W       = 9;
   localparam int ROW_W     = 8;
   localparam int COL_W     = 8;
   localparam int MASK_W    = 4;
   localparam int BYTE_W    = 8;
   localparam int TEX_AW    = 12;
   localparam int SHADE_AW  = 8;
   localparam int TEX_DEPTH = 1 << TEX_AW;
   localparam int SHADE_DEPTH = 1 << SHADE_AW;
   localparam int UV_W      = 32;
   localparam int FRAC_W    = 16;
   localparam int TEX_BITS  = 6;
   // Only the fraction and the six wrapped integer bits of u and v matter.
   localparam int COORD_W   = FRAC_W + TEX_BITS;

   localparam int REQ_DATA_W = 176;
   localparam int RSP_DATA_W = 32;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [X_W-1:0]    X_LAST   = X_W'(SCREEN_WIDTH - 1);
   localparam logic [MASK_W-1:0] MASK_EVEN = 4'b0011;
   localparam logic [MASK_W-1:0] MASK_ODD  = 4'b1100;

   typedef enum logic [1:0] {
      OP_TEX_WRITE   = 2'd0,
      OP_SHADE_WRITE = 2'd1,
      OP_SPAN_START  = 2'd2,
      OP_NEXT_PIXEL  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CMD_TEX   = 2'd0,
      CMD_SHADE = 2'd1,
      CMD_SPAN  = 2'd2,
      CMD_PIXEL = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      op_type                  op;
      logic [TEX_AW-1:0]       table_index;
      logic [BYTE_W-1:0]       table_value;
      logic [X_W-1:0]          x_start;
      logic [X_W-1:0]          x_end;
      logic [ROW_W-1:0]        row;
      logic signed [UV_W-1:0]  u_start;
      logic signed [UV_W-1:0]  v_start;
      logic signed [UV_W-1:0]  u_step;
      logic signed [UV_W-1:0]  v_step;
   } req_type;

   typedef struct packed {
      logic [MASK_W-1:0] mask;
      logic [COL_W-1:0]  column;
      logic [ROW_W-1:0]  row;
      logic              last;
   } pix_info_type;

   typedef struct packed {
      cmd_kind_type         kind;
      logic [TEX_AW-1:0]    index;
      logic [BYTE_W-1:0]    value;
      logic [X_W-1:0]       delta_x;
      pix_info_type         pix;
      logic [COORD_W-1:0]   u0;
      logic [COORD_W-1:0]   v0;
      logic [COORD_W-1:0]   du;
      logic [COORD_W-1:0]   dv;
   } cmd_type;

   typedef struct packed {
      pix_info_type      pix;
      logic [BYTE_W-1:0] color;
   } rsp_type;

endpackage

// ----- rtl/tspan_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tspan_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/tspan_front.sv -----
// Front end: accept items, keep span walk state, emit commands in order.
module tspan_front
   import tspan_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_req,
   input  logic    low_detail,
   input  logic    q_full,
   output logic    q_push,
   output cmd_type q_cmd
);

   typedef struct packed {
      logic           found;
      logic [1:0]     pass;
      logic [X_W-1:0] x;
   } seek_type;

   logic [X_W-1:0]   span_left_ff, span_left_in;
   logic [X_W-1:0]   span_right_ff, span_right_in;
   logic [ROW_W-1:0] span_row_ff, span_row_in;
   logic [1:0]       pass_ff, pass_in;
   logic [X_W-1:0]   next_x_ff, next_x_in;
   logic             busy_ff, busy_in;

   logic             accept;
   logic [X_W-1:0]   clamp_right;
   seek_type         start_seek;
   seek_type         step_seek;
   logic [X_W:0]     step_nx;

   // First pixel at or after pass from_p; lowest eligible pass wins.
   function automatic seek_type seek(input logic [2:0] from_p,
                                     input logic [X_W-1:0] left,
                                     input logic [X_W-1:0] right,
                                     input logic low);
      seek_type   r;
      logic [1:0] pp;
      logic [1:0] off;
      logic [X_W:0] x;
      r = '0;
      for (int p = 3; p >= 0; p--) begin
         pp  = 2'(p);
         off = low ? {1'b0, pp[0] ^ left[0]} : 2'(pp - left[1:0]);
         x   = {1'b0, left} + {{(X_W-1){1'b0}}, off};
         if ((3'(p) >= from_p) && (!low || (p < 2)) && (x <= {1'b0, right})) begin
            r.found = 1'b1;
            r.pass  = pp;
            r.x     = x[X_W-1:0];
         end
      end
      return r;
   endfunction

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;

   assign clamp_right = (in_req.x_end > X_LAST) ? X_LAST : in_req.x_end;
   assign start_seek  = seek(3'd0, in_req.x_start, clamp_right, low_detail);
   assign step_nx     = {1'b0, next_x_ff} + (low_detail ? (X_W+1)'(2) : (X_W+1)'(4));
   assign step_seek   = seek({1'b0, pass_ff} + 3'd1, span_left_ff, span_right_ff, low_detail);

   always_comb begin
      span_left_in  = span_left_ff;
      span_right_in = span_right_ff;
      span_row_in   = span_row_ff;
      pass_in       = pass_ff;
      next_x_in     = next_x_ff;
      busy_in       = busy_ff;
      q_push        = 1'b0;
      q_cmd         = '0;
      q_cmd.index   = in_req.table_index;
      q_cmd.value   = in_req.table_value;
      q_cmd.u0      = in_req.u_start[COORD_W-1:0];
      q_cmd.v0      = in_req.v_start[COORD_W-1:0];
      q_cmd.du      = in_req.u_step[COORD_W-1:0];
      q_cmd.dv      = in_req.v_step[COORD_W-1:0];
      if (accept) begin
         case (in_req.op)
            OP_TEX_WRITE: begin
               q_push     = 1'b1;
               q_cmd.kind = CMD_TEX;
            end
            OP_SHADE_WRITE: begin
               q_push     = 1'b1;
               q_cmd.kind = CMD_SHADE;
            end
            OP_SPAN_START: begin
               q_push        = 1'b1;
               q_cmd.kind    = CMD_SPAN;
               span_left_in  = in_req.x_start;
               span_right_in = clamp_right;
               span_row_in   = in_req.row;
               busy_in       = start_seek.found;
               pass_in       = start_seek.found ? start_seek.pass : 2'd0;
               next_x_in     = start_seek.found ? start_seek.x : '0;
            end
            OP_NEXT_PIXEL: begin
               if (busy_ff) begin
                  if (low_detail && pass_ff[1]) begin
                     // pass left over from high detail: end the span quietly
                     busy_in = 1'b0;
                  end else begin
                     q_push          = 1'b1;
                     q_cmd.kind      = CMD_PIXEL;
                     q_cmd.delta_x   = next_x_ff - span_left_ff;
                     q_cmd.pix.row   = span_row_ff;
                     if (low_detail) begin
                        q_cmd.pix.mask   = pass_ff[0] ? MASK_ODD : MASK_EVEN;
                        q_cmd.pix.column = next_x_ff[X_W-1:1];
                     end else begin
                        q_cmd.pix.mask   = MASK_W'(1) << pass_ff;
                        q_cmd.pix.column = {1'b0, next_x_ff[X_W-1:2]};
                     end
                     if (step_nx <= {1'b0, span_right_ff}) begin
                        next_x_in = step_nx[X_W-1:0];
                     end else begin
                        busy_in = step_seek.found;
                        if (step_seek.found) begin
                           pass_in   = step_seek.pass;
                           next_x_in = step_seek.x;
                        end
                     end
                     q_cmd.pix.last = !busy_in;
                  end
               end
            end
            default: begin
               q_push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         span_left_ff  <= '0;
         span_right_ff <= '0;
         span_row_ff   <= '0;
         pass_ff       <= '0;
         next_x_ff     <= '0;
         busy_ff       <= 1'b0;
      end else begin
         span_left_ff  <= span_left_in;
         span_right_ff <= span_right_in;
         span_row_ff   <= span_row_in;
         pass_ff       <= pass_in;
         next_x_ff     <= next_x_in;
         busy_ff       <= busy_in;
      end
   end

endmodule

// ----- rtl/tspan_queue.sv -----
// Short command queue between the front end and the pixel pipeline.
module tspan_queue
   import tspan_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type head_cmd
);

   cmd_type             entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = entries_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? QUEUE_AW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? QUEUE_AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/tspan_back.sv -----
// Back end: coordinate stage, texture read, shade read, output register.
module tspan_back
   import tspan_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_rsp
);

   logic                 en;

   logic [COORD_W-1:0]   base_u_ff, base_v_ff, delta_u_ff, delta_v_ff;
   logic [COORD_W-1:0]   u_sum, v_sum;

   // stage A: texture RAM access
   logic                 a_valid_ff;
   cmd_kind_type         a_kind_ff;
   logic [TEX_AW-1:0]    a_index_ff, a_index_in;
   logic [BYTE_W-1:0]    a_value_ff;
   pix_info_type         a_pix_ff;

   // stage B: shade RAM access
   logic                 b_valid_ff;
   cmd_kind_type         b_kind_ff;
   logic [SHADE_AW-1:0]  b_index_ff;
   logic [BYTE_W-1:0]    b_value_ff;
   pix_info_type         b_pix_ff;

   // stage C: result register
   logic                 c_valid_ff;
   pix_info_type         c_pix_ff;

   logic [BYTE_W-1:0]    texel;
   logic [BYTE_W-1:0]    shade;

   assign en      = !c_valid_ff || out_ready;
   assign cmd_pop = en && cmd_valid;

   assign u_sum = base_u_ff + delta_u_ff * COORD_W'(cmd.delta_x);
   assign v_sum = base_v_ff + delta_v_ff * COORD_W'(cmd.delta_x);

   always_comb begin
      a_index_in = cmd.index;
      if (cmd.kind == CMD_PIXEL) begin
         a_index_in = {v_sum[COORD_W-1:FRAC_W], u_sum[COORD_W-1:FRAC_W]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_u_ff  <= '0;
         base_v_ff  <= '0;
         delta_u_ff <= '0;
         delta_v_ff <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (en) begin
         if (cmd_valid && cmd.kind == CMD_SPAN) begin
            base_u_ff  <= cmd.u0;
            base_v_ff  <= cmd.v0;
            delta_u_ff <= cmd.du;
            delta_v_ff <= cmd.dv;
         end
         a_valid_ff <= cmd_valid && (cmd.kind != CMD_SPAN);
         b_valid_ff <= a_valid_ff && (a_kind_ff != CMD_TEX);
         c_valid_ff <= b_valid_ff && (b_kind_ff == CMD_PIXEL);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_kind_ff  <= cmd.kind;
         a_index_ff <= a_index_in;
         a_value_ff <= cmd.value;
         a_pix_ff   <= cmd.pix;
         b_kind_ff  <= a_kind_ff;
         b_index_ff <= a_index_ff[SHADE_AW-1:0];
         b_value_ff <= a_value_ff;
         b_pix_ff   <= a_pix_ff;
         c_pix_ff   <= b_pix_ff;
      end
   end

   tspan_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (TEX_DEPTH)
   ) u_texture (
      .clock   (clock),
      .wr_en   (en && a_valid_ff && a_kind_ff == CMD_TEX),
      .wr_addr (a_index_ff),
      .wr_data (a_value_ff),
      .rd_en   (en),
      .rd_addr (a_index_ff),
      .rd_data (texel)
   );

   tspan_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (SHADE_DEPTH)
   ) u_shade (
      .clock   (clock),
      .wr_en   (en && b_valid_ff && b_kind_ff == CMD_SHADE),
      .wr_addr (b_index_ff),
      .wr_data (b_value_ff),
      .rd_en   (en),
      .rd_addr (texel),
      .rd_data (shade)
   );

   assign out_valid     = c_valid_ff;
   assign out_rsp.pix   = c_pix_ff;
   assign out_rsp.color = shade;

endmodule

// ----- rtl/planar_texture_span_drawer_core.sv -----
// Planar affine texture span drawer: top level with ports and mode register.
//
// Draws one horizontal span of a 64x64 texture, affine in 16.16 fixed point,
// and sends its pixels grouped by plane: in high detail all x mod 4 = 0 pixels
// first, then 1, 2 and 3, each with a one-hot plane mask and column x/4; in
// low detail even x (mask 3) and then odd x (mask 12), column x/2. A request
// with op 0 writes a texel, op 1 writes the shade table, op 2 starts a span
// (x_end is clamped to the last screen column; a span that ends before it
// starts draws nothing), op 3 asks for the next pixel and gets exactly one
// result while the span lasts, none otherwise. rsp_tlast marks the final
// pixel. Throughput is one request per clock while the queue has room: the
// front end walks the span one pixel per next-pixel request, a four-entry
// command queue follows, and the back end is a three-stage pipeline
// (coordinate multiply-add into the texel address, texture RAM read, shade
// RAM read whose read register holds the result). rsp_tvalid is registered
// behind the queue and the stage A and B registers. While rsp_tready is low,
// up to seven requests sit in the queue and pipeline before req_tready drops.
// Table writes act in request order on later pixels. The texture and
// shade tables power up unwritten; write every entry a span can touch.
// Write low_detail only while no request is in flight; a running span takes
// the new mode from its next pixel request on.
module planar_texture_span_drawer_core
   import tspan_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // mode register write: csr_data = low_detail
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_data,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // table_index[11:0], table_value[19:12], x_start[28:20], x_end[37:29],
   // row[45:38], u_start[77:46], v_start[109:78], u_step[141:110],
   // v_step[173:142], zero [175:174]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // op[1:0]
   input  logic [1:0]            req_tuser,
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // plane_mask[3:0], plane_column[11:4], pixel_row[19:12], color[27:20],
   // zero [31:28]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   logic    low_detail_ff;
   req_type req;
   logic    q_push, q_full, q_pop, q_empty;
   cmd_type q_in_cmd, q_head_cmd;
   rsp_type rsp;

   // Mode register: always ready, take the write on every transfer.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_detail_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         low_detail_ff <= csr_data;
      end
   end

   // Unpack the request payload, lowest field first.
   assign req.op          = op_type'(req_tuser);
   assign req.table_index = req_tdata[11:0];
   assign req.table_value = req_tdata[19:12];
   assign req.x_start     = req_tdata[28:20];
   assign req.x_end       = req_tdata[37:29];
   assign req.row         = req_tdata[45:38];
   assign req.u_start     = req_tdata[77:46];
   assign req.v_start     = req_tdata[109:78];
   assign req.u_step      = req_tdata[141:110];
   assign req.v_step      = req_tdata[173:142];

   tspan_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_req     (req),
      .low_detail (low_detail_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_in_cmd)
   );

   tspan_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_in_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head_cmd (q_head_cmd)
   );

   tspan_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!q_empty),
      .cmd       (q_head_cmd),
      .cmd_pop   (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rsp   (rsp)
   );

   // Pack the result payload, lowest field first.
   assign rsp_tdata = {4'b0000, rsp.color, rsp.pix.row, rsp.pix.column, rsp.pix.mask};
   assign rsp_tlast = rsp.pix.last;

`ifndef NO_ASSERTIONS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("command pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("command popped from an empty queue");

   a_mask_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($onehot(rsp.pix.mask) || rsp.pix.mask == MASK_EVEN ||
                      rsp.pix.mask == MASK_ODD))
      else $error("plane mask is neither one-hot nor a plane pair");
`endif

endmodule
